/* rtl/xed_pkg.sv */
`timescale 1ns / 1ps

package xed_pkg;

    localparam int XED_NAME_MAX = 32;
    localparam int XED_LEN_W    = 6;
    localparam int XED_CP_W     = 21;

    localparam logic [XED_CP_W-1:0] XED_CP_SAT = 21'h1FFFFF;
    localparam logic [XED_CP_W-1:0] XED_CP_2B  = 21'h00080;
    localparam logic [XED_CP_W-1:0] XED_CP_3B  = 21'h00800;
    localparam logic [XED_CP_W-1:0] XED_CP_4B  = 21'h10000;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_MASK  = 8'h3F;

    // Known names: lt, gt, amp, quot; text packed left-aligned in 32 bits
    localparam int XED_NUM_KW = 4;
    localparam logic [31:0] KW_TEXT [XED_NUM_KW] = '{
        32'h6C74_0000, 32'h6774_0000, 32'h616D_7000, 32'h7175_6F74
    };
    localparam logic [2:0] KW_LEN [XED_NUM_KW] = '{3'd2, 3'd2, 3'd3, 3'd4};
    localparam logic [7:0] KW_OUT [XED_NUM_KW] = '{CH_LT, CH_GT, CH_AMP, CH_QUOT};

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_UTF8   = 2'd1,
        CMD_REPLAY = 2'd2,
        CMD_END    = 2'd3
    } t_cmd_kind;

    // At most one command per accepted item. data holds the byte, the code point,
    // or the trailing byte of a literal replay.
    typedef struct packed {
        t_cmd_kind             kind;
        logic                  eos;
        logic [XED_CP_W-1:0]   data;
        logic [XED_LEN_W-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic hold;
        logic in_entity;
    } t_front_stat;

    function automatic logic [7:0] kw_char(input int k, input logic [1:0] i);
        logic [31:0] txt;
        txt = KW_TEXT[k];
        case (i)
            2'd0:    kw_char = txt[31:24];
            2'd1:    kw_char = txt[23:16];
            2'd2:    kw_char = txt[15:8];
            default: kw_char = txt[7:0];
        endcase
    endfunction

    // Index of the last UTF-8 byte for a nonzero code point
    function automatic logic [1:0] utf8_last(input logic [XED_CP_W-1:0] cp);
        if (cp < XED_CP_2B) begin
            utf8_last = 2'd0;
        end else if (cp < XED_CP_3B) begin
            utf8_last = 2'd1;
        end else if (cp < XED_CP_4B) begin
            utf8_last = 2'd2;
        end else begin
            utf8_last = 2'd3;
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [XED_CP_W-1:0] cp,
                                             input logic [1:0] pos);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        c0 = UTF_CONT | ({2'b00, cp[5:0]} & UTF_MASK);
        c1 = UTF_CONT | ({2'b00, cp[11:6]} & UTF_MASK);
        c2 = UTF_CONT | ({2'b00, cp[17:12]} & UTF_MASK);
        unique case (utf8_last(cp))
            2'd0: utf8_byte = cp[7:0];
            2'd1: utf8_byte = (pos == 2'd0) ? (UTF_LEAD2 | {3'b000, cp[10:6]}) : c0;
            2'd2: begin
                case (pos)
                    2'd0:    utf8_byte = UTF_LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    utf8_byte = c1;
                    default: utf8_byte = c0;
                endcase
            end
            default: begin
                case (pos)
                    2'd0:    utf8_byte = UTF_LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    utf8_byte = c2;
                    2'd2:    utf8_byte = c1;
                    default: utf8_byte = c0;
                endcase
            end
        endcase
    endfunction

endpackage

/* rtl/xed_if.sv */
`timescale 1ns / 1ps

interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       run_last;

    modport source (output valid, output out_byte, output has_byte, output string_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input string_end,
                    input run_last, output ready);
endinterface

/* rtl/xml_entity_decoder_utf8_unit.sv */
`timescale 1ns / 1ps

// Channel  Dir  Fields                                        Item
// i_in     in   in_byte[7:0], end_of_string                   one text byte
// o_out    out  out_byte[7:0], has_byte, string_end, run_last one decoded byte or end mark
//
// A plain byte or a known name gives one result byte and a nonzero code point
// its UTF-8 bytes; the front takes one item per cycle while the two-entry queue
// has room and no replay is pending. A literal replay (unknown or overlong
// name) sends name length + 2 bytes, one per cycle while the output does not
// stall; the front holds off input until the last one is emitted.
// Synchronous active-low reset clears the mode, name length, replay hold,
// queue and back end. Either side may stall at any time.

module xml_entity_decoder_utf8_unit import xed_pkg::*; #(
    parameter int NAME_MAX = XED_NAME_MAX
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xed_in_if.sink    i_in,
    xed_out_if.source o_out
);

    localparam int AW = $clog2(NAME_MAX);

    t_cmd          q_push_cmd;
    t_cmd          q_cmd;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic          replay_done;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    t_front_stat   fstat;

    xed_front #(.NAME_MAX(NAME_MAX)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_push_cmd),
        .i_replay_done (replay_done),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_stat        (fstat)
    );

    xed_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_name_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    xed_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd)
    );

    xed_back #(.NAME_MAX(NAME_MAX)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_replay_done (replay_done),
        .o_out         (o_out)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_replay_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && q_push_cmd.kind == CMD_REPLAY) |=> fstat.hold)
        else $error("input not held after a replay was queued");

    a_done_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        replay_done |-> fstat.hold)
        else $error("replay finished with no replay pending");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_end) |-> o_out.run_last)
        else $error("string end on an item that is not the last of its run");

endmodule

/* rtl/xed_ram.sv */
`timescale 1ns / 1ps

module xed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/xed_front.sv */
`timescale 1ns / 1ps

module xed_front import xed_pkg::*; #(
    parameter int NAME_MAX = XED_NAME_MAX,
    localparam int AW      = $clog2(NAME_MAX),
    localparam int LW      = $clog2(NAME_MAX + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xed_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_q_push,
    output t_cmd          o_q_cmd,
    input  logic          i_replay_done,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output t_front_stat   o_stat
);

    logic                  r_in_entity, n_in_entity;
    logic [LW-1:0]         r_len, n_len;
    logic                  r_hold, n_hold;
    logic                  r_hash, n_hash;
    logic                  r_num_ok, n_num_ok;
    logic [XED_CP_W-1:0]   r_cp, n_cp;
    logic [XED_NUM_KW-1:0] r_kw, n_kw;

    logic                  acc;
    logic                  have;
    t_cmd                  cmd;
    logic [7:0]            b;
    logic                  digit;
    logic [7:0]            digit_v;
    logic [24:0]           cp_mul;
    logic [XED_CP_W-1:0]   cp_sat;
    logic [XED_NUM_KW-1:0] hit;
    logic [7:0]            hit_byte;

    assign b        = i_in.in_byte;
    assign i_in.ready = !r_hold && !i_q_full;
    assign acc      = i_in.valid && i_in.ready;
    assign digit    = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit_v  = b - CH_ZERO;
    assign cp_mul   = ({4'b0, r_cp} << 3) + ({4'b0, r_cp} << 1) + {17'b0, digit_v};
    assign cp_sat   = (cp_mul > {4'b0, XED_CP_SAT}) ? XED_CP_SAT : cp_mul[XED_CP_W-1:0];

    always_comb begin
        hit_byte = 8'h00;
        for (int k = 0; k < XED_NUM_KW; k++) begin
            hit[k] = r_kw[k] && (r_len == LW'(KW_LEN[k]));
            if (hit[k]) begin
                hit_byte = KW_OUT[k];
            end
        end
    end

    always_comb begin
        n_in_entity = r_in_entity;
        n_len       = r_len;
        n_hash      = r_hash;
        n_num_ok    = r_num_ok;
        n_cp        = r_cp;
        n_kw        = r_kw;
        have        = 1'b0;
        cmd.kind    = CMD_END;
        cmd.eos     = i_in.end_of_string;
        cmd.data    = '0;
        cmd.len     = '0;
        o_wr_en     = 1'b0;

        if (!r_in_entity) begin
            if (b == CH_AMP) begin
                n_in_entity = 1'b1;
                n_len       = '0;
            end else begin
                have      = 1'b1;
                cmd.kind  = CMD_BYTE;
                cmd.data  = {13'b0, b};
            end
        end else if (b == CH_SEMI) begin
            n_in_entity = 1'b0;
            n_len       = '0;
            if (|hit) begin
                have     = 1'b1;
                cmd.kind = CMD_BYTE;
                cmd.data = {13'b0, hit_byte};
            end else if (r_len > LW'(1) && r_hash) begin
                // code point zero gives no output
                if (r_cp != '0) begin
                    have     = 1'b1;
                    cmd.kind = CMD_UTF8;
                    cmd.data = r_cp;
                end
            end else begin
                have     = 1'b1;
                cmd.kind = CMD_REPLAY;
                cmd.data = {13'b0, b};
                cmd.len  = XED_LEN_W'(r_len);
            end
        end else if (r_len < LW'(NAME_MAX)) begin
            o_wr_en = acc;
            n_len   = r_len + LW'(1);
            if (r_len == '0) begin
                n_hash   = (b == CH_HASH);
                n_num_ok = 1'b1;
                n_cp     = '0;
                for (int k = 0; k < XED_NUM_KW; k++) begin
                    n_kw[k] = (b == kw_char(k, 2'd0));
                end
            end else begin
                if (r_num_ok && digit) begin
                    n_cp = cp_sat;
                end else begin
                    n_num_ok = 1'b0;
                end
                for (int k = 0; k < XED_NUM_KW; k++) begin
                    n_kw[k] = (r_len < LW'(4)) && r_kw[k] && (b == kw_char(k, r_len[1:0]));
                end
            end
        end else begin
            // name too long: replay it as text, the current byte last
            n_in_entity = 1'b0;
            n_len       = '0;
            have        = 1'b1;
            cmd.kind    = CMD_REPLAY;
            cmd.data    = {13'b0, b};
            cmd.len     = XED_LEN_W'(r_len);
        end

        if (i_in.end_of_string) begin
            n_in_entity = 1'b0;
            n_len       = '0;
            if (!have) begin
                have     = 1'b1;
                cmd.kind = CMD_END;
                cmd.data = '0;
            end
        end

        n_hold = r_hold;
        if (acc && have && cmd.kind == CMD_REPLAY) begin
            n_hold = 1'b1;
        end else if (i_replay_done) begin
            n_hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_entity <= 1'b0;
            r_len       <= '0;
            r_hold      <= 1'b0;
        end else begin
            r_hold <= n_hold;
            if (acc) begin
                r_in_entity <= n_in_entity;
                r_len       <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_hash   <= n_hash;
            r_num_ok <= n_num_ok;
            r_cp     <= n_cp;
            r_kw     <= n_kw;
        end
    end

    assign o_q_push         = acc && have;
    assign o_q_cmd          = cmd;
    assign o_wr_addr        = r_len[AW-1:0];
    assign o_wr_data        = b;
    assign o_stat.hold      = r_hold;
    assign o_stat.in_entity = r_in_entity;

endmodule

/* rtl/xed_queue.sv */
`timescale 1ns / 1ps

module xed_queue import xed_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

/* rtl/xed_back.sv */
`timescale 1ns / 1ps

module xed_back import xed_pkg::*; #(
    parameter int NAME_MAX = XED_NAME_MAX,
    localparam int AW      = $clog2(NAME_MAX)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_q_cmd,
    output logic          o_q_pop,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    output logic          o_replay_done,
    xed_out_if.source     o_out
);

    logic                 r_busy, n_busy;
    t_cmd                 r_cmd;
    logic [XED_LEN_W-1:0] r_pos, n_pos;
    logic [XED_LEN_W-1:0] r_last, n_last;
    logic                 r_o_valid;
    logic [7:0]           r_o_byte;
    logic                 r_o_has;
    logic                 r_o_end;
    logic                 r_o_run_last;

    logic                 load_ok;
    logic                 emit;
    logic                 is_last;
    logic                 pop;
    logic [7:0]           sel_byte;
    logic [XED_LEN_W-1:0] rd_pos;

    assign load_ok = !r_o_valid || o_out.ready;
    assign emit    = r_busy && load_ok;
    assign is_last = (r_pos == r_last);
    assign pop     = i_q_valid && (!r_busy || (emit && is_last));

    always_comb begin
        case (r_cmd.kind)
            CMD_BYTE:   sel_byte = r_cmd.data[7:0];
            CMD_UTF8:   sel_byte = utf8_byte(r_cmd.data, r_pos[1:0]);
            CMD_REPLAY: begin
                if (r_pos == '0) begin
                    sel_byte = CH_AMP;
                end else if (is_last) begin
                    sel_byte = r_cmd.data[7:0];
                end else begin
                    sel_byte = i_rd_data;
                end
            end
            default:    sel_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (i_q_cmd.kind)
            CMD_UTF8:   n_last = {{(XED_LEN_W-2){1'b0}}, utf8_last(i_q_cmd.data)};
            CMD_REPLAY: n_last = i_q_cmd.len + XED_LEN_W'(1);
            default:    n_last = '0;
        endcase

        if (pop) begin
            n_pos  = '0;
            n_busy = 1'b1;
        end else if (emit) begin
            n_pos  = r_pos + XED_LEN_W'(1);
            n_busy = !is_last;
        end else begin
            n_pos  = r_pos;
            n_busy = r_busy;
        end
    end

    // Address the name byte one position ahead, so the registered read
    // lines up with the position being emitted.
    assign rd_pos    = n_pos - XED_LEN_W'(1);
    assign o_rd_addr = rd_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pos     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd  <= i_q_cmd;
            r_last <= n_last;
        end
        if (emit) begin
            r_o_byte     <= sel_byte;
            r_o_has      <= (r_cmd.kind != CMD_END);
            r_o_end      <= r_cmd.eos && is_last;
            r_o_run_last <= is_last;
        end
    end

    assign o_q_pop          = pop;
    assign o_replay_done    = emit && is_last && (r_cmd.kind == CMD_REPLAY);
    assign o_out.valid      = r_o_valid;
    assign o_out.out_byte   = r_o_byte;
    assign o_out.has_byte   = r_o_has;
    assign o_out.string_end = r_o_end;
    assign o_out.run_last   = r_o_run_last;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import xed_pkg::*;

    localparam int NUM_ITEMS = 170;
    localparam int LONG_HOLD = 200;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       string_end;
        logic       run_last;
    } dec_result_t;

    // Tracks the decoder's text/entity mode and queues the output items
    // that each accepted text byte should produce.
    class entity_expander;
        bit          in_entity;
        logic [7:0]  name_buf [XED_NAME_MAX];
        int          name_len;
        dec_result_t burst [$];
        dec_result_t pending [$];
        int          mismatches;

        function new();
            in_entity  = 1'b0;
            name_len   = 0;
            mismatches = 0;
        endfunction

        function void emit(logic [7:0] b);
            dec_result_t r;
            r = '{out_byte: b, has_byte: 1'b1, string_end: 1'b0, run_last: 1'b0};
            burst = {burst, r};
        endfunction

        function bit name_is(string s);
            if (name_len != s.len()) return 1'b0;
            for (int i = 0; i < name_len; i++) begin
                if (name_buf[i] != s[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void replay_name();
            emit(CH_AMP);
            for (int i = 0; i < name_len; i++) emit(name_buf[i]);
        endfunction

        function void absorb_byte(logic [7:0] b, logic eos);
            logic [31:0] cp;
            dec_result_t tail;
            burst = {};
            if (!in_entity) begin
                if (b == CH_AMP) begin
                    in_entity = 1'b1;
                    name_len  = 0;
                end else begin
                    emit(b);
                end
            end else if (b == CH_SEMI) begin
                if (name_is("lt")) begin
                    emit(CH_LT);
                end else if (name_is("gt")) begin
                    emit(CH_GT);
                end else if (name_is("amp")) begin
                    emit(CH_AMP);
                end else if (name_is("quot")) begin
                    emit(CH_QUOT);
                end else if (name_len > 1 && name_buf[0] == CH_HASH) begin
                    // decimal digits up to the first non-digit, saturating
                    cp = 32'd0;
                    for (int i = 1; i < name_len; i++) begin
                        if (name_buf[i] < CH_ZERO || name_buf[i] > CH_NINE) break;
                        cp = cp * 10 + 32'(name_buf[i] - CH_ZERO);
                        if (cp > 32'(XED_CP_SAT)) cp = 32'(XED_CP_SAT);
                    end
                    if (cp != 32'd0) begin
                        if (cp < 32'(XED_CP_2B)) begin
                            emit(cp[7:0]);
                        end else if (cp < 32'(XED_CP_3B)) begin
                            emit(UTF_LEAD2 | 8'(cp[10:6]));
                            emit(UTF_CONT | 8'(cp[5:0]));
                        end else if (cp < 32'(XED_CP_4B)) begin
                            emit(UTF_LEAD3 | 8'(cp[15:12]));
                            emit(UTF_CONT | 8'(cp[11:6]));
                            emit(UTF_CONT | 8'(cp[5:0]));
                        end else begin
                            emit(UTF_LEAD4 | 8'(cp[20:18]));
                            emit(UTF_CONT | 8'(cp[17:12]));
                            emit(UTF_CONT | 8'(cp[11:6]));
                            emit(UTF_CONT | 8'(cp[5:0]));
                        end
                    end
                end else begin
                    replay_name();
                    emit(CH_SEMI);
                end
                in_entity = 1'b0;
                name_len  = 0;
            end else if (name_len < XED_NAME_MAX) begin
                name_buf[name_len] = b;
                name_len++;
            end else begin
                // name overflow: flush as literal text
                replay_name();
                emit(b);
                in_entity = 1'b0;
                name_len  = 0;
            end

            if (eos) begin
                in_entity = 1'b0;
                name_len  = 0;
                if (burst.size() == 0) begin
                    tail = '0;
                    burst = {burst, tail};
                end
                tail = burst[burst.size() - 1];
                tail.string_end = 1'b1;
                burst[burst.size() - 1] = tail;
            end
            if (burst.size() > 0) begin
                tail = burst[burst.size() - 1];
                tail.run_last = 1'b1;
                burst[burst.size() - 1] = tail;
            end
            pending = {pending, burst};
        endfunction

        function void match_output(dec_result_t got);
            dec_result_t want;
            if (pending.size() == 0) begin
                $error("unexpected output item: out_byte=%02h has_byte=%0b string_end=%0b run_last=%0b",
                       got.out_byte, got.has_byte, got.string_end, got.run_last);
                mismatches++;
            end else begin
                want = pending.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                    mismatches++;
                end
                if (got.has_byte !== want.has_byte) begin
                    $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
                    mismatches++;
                end
                if (got.string_end !== want.string_end) begin
                    $error("string_end: expected %0b, got %0b", want.string_end, got.string_end);
                    mismatches++;
                end
                if (got.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                    mismatches++;
                end
            end
        endfunction

        function bit clean();
            if (pending.size() != 0) begin
                $error("%0d expected output items never arrived", pending.size());
                mismatches++;
            end
            return mismatches == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    xed_in_if  in_ch ();
    xed_out_if out_ch ();

    xml_entity_decoder_utf8_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    entity_expander sb = new();

    logic [7:0] token [$];
    int         tx_sent;
    bit         tx_calm;
    string      kw_names [4] = '{"lt", "gt", "amp", "quot"};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Both channels are sampled before any edge update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.absorb_byte(in_ch.in_byte, in_ch.end_of_string);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.match_output('{out_byte: out_ch.out_byte, has_byte: out_ch.has_byte,
                                  string_end: out_ch.string_end, run_last: out_ch.run_last});
            end
        end
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) token = {token, s[i]};
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_SEMI);
        return b;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        if (tx_sent % 24 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        tx_sent++;
    endtask

    task automatic send_token(input bit eos);
        for (int i = 0; i < token.size(); i++) begin
            send_item(token[i], eos && (i == token.size() - 1));
        end
    endtask

    // Output side: random stalls, calm stretches, and one long hold-off
    // so the block backs up into its input.
    initial begin : out_drain
        int stall;
        int taken;
        bit calm;
        bit held;
        taken = 0;
        calm  = 1'b0;
        held  = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken % 24 == 0) calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 9);
            if (!held && taken == 40) begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    initial begin : stimulus
        int          pick;
        int          cls;
        int unsigned cp_val;
        bit          eos;
        bit          broken;
        logic [7:0]  b;

        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= 8'h00;
        in_ch.end_of_string <= 1'b0;
        tx_sent = 0;
        tx_calm = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every known name, multi-byte code points,
        // saturation, lone-hash and empty names, zero, open entity at end,
        // longest name and overflow.
        token = {8'h00, 8'hFF};
        send_token(1'b1);
        token = {};
        add_text("&lt;&gt;&amp;&quot;");
        send_token(1'b1);
        token = {};
        add_text("&#233;&#8364;&#65536;");
        send_token(1'b0);
        token = {};
        add_text("&#9999999;&#;&;");
        send_token(1'b1);
        token = {};
        add_text("&#0;");
        send_token(1'b1);
        token = {CH_AMP};
        send_token(1'b1);
        // longest name that still fits, then one byte too many
        token = {CH_AMP};
        repeat (XED_NAME_MAX) token = {token, name_byte()};
        token = {token, CH_SEMI};
        send_token(1'b0);
        token = {CH_AMP};
        repeat (XED_NAME_MAX + 1) token = {token, name_byte()};
        send_token(1'b1);

        while (tx_sent < NUM_ITEMS) begin
            token  = {};
            broken = 1'b0;
            pick   = $urandom_range(0, 99);
            if (pick < 35) begin
                repeat ($urandom_range(1, 4)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_AMP);
                    token = {token, b};
                end
            end else if (pick < 55) begin
                add_text({"&", kw_names[$urandom_range(0, 3)], ";"});
            end else if (pick < 75) begin
                cls = $urandom_range(0, 4);
                case (cls)
                    0:       cp_val = $urandom_range(0, 'h7F);
                    1:       cp_val = $urandom_range('h80, 'h7FF);
                    2:       cp_val = $urandom_range('h800, 'hFFFF);
                    3:       cp_val = $urandom_range('h10000, 'h1FFFFF);
                    default: cp_val = $urandom_range('h200000, 99999999);
                endcase
                add_text($sformatf("&#%0d;", cp_val));
            end else if (pick < 87) begin
                token = {token, CH_AMP};
                repeat ($urandom_range(0, 6)) token = {token, name_byte()};
                token = {token, CH_SEMI};
            end else if (pick < 90) begin
                token = {token, CH_AMP};
                repeat (XED_NAME_MAX + 1) token = {token, name_byte()};
            end else begin
                // entity cut off by the end of the string
                token = {token, CH_AMP};
                repeat ($urandom_range(0, 5)) token = {token, name_byte()};
                broken = 1'b1;
            end
            eos = broken || ($urandom_range(0, 5) == 0);
            send_token(eos);
        end
        in_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (XED_NAME_MAX + 30) @(posedge i_clk);

        if (sb.clean()) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/xed_pkg.sv
rtl/xed_if.sv
rtl/xed_ram.sv
rtl/xed_front.sv
rtl/xed_queue.sv
rtl/xed_back.sv
rtl/xml_entity_decoder_utf8_unit.sv
test/tb_top.sv
